>>> rtl/core/slsu_pkg.sv
// shared constants and register codes for the stochastic lattice site update block
`timescale 1ns / 1ps
`default_nettype none
package slsu_pkg;

  localparam int unsigned SITES_DEF          = 4096;
  localparam int unsigned MAX_NEIGHBOURS_DEF = 24;
  localparam int unsigned PROB_BITS_DEF      = 32;

  localparam int unsigned SITE_FW   = 12;
  localparam int unsigned SLOT_FW   = 5;
  localparam int unsigned KIND_FW   = 2;
  localparam int unsigned REG_W     = 32;
  localparam int unsigned NIU_W     = 5;
  localparam int unsigned SIU_W     = 13;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [KIND_FW-1:0] KIND_LOAD_SITE  = 2'd0;
  localparam logic [KIND_FW-1:0] KIND_LOAD_NEIGH = 2'd1;
  localparam logic [KIND_FW-1:0] KIND_UPDATE     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SELF_PROB  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGH_PROB = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_PROB = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGH_USE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SITES_USE  = 3'd4;

endpackage
`default_nettype wire

>>> rtl/core/slsu_qmul.sv
// shared fixed-point multiplier for survival products, one registered result a cycle
`timescale 1ns / 1ps
`default_nettype none
module slsu_qmul import slsu_pkg::*; #(
  parameter int unsigned PROB_BITS = PROB_BITS_DEF
) (
  input  wire                  clk_i,
  input  wire  [PROB_BITS:0]   a_i,
  input  wire  [PROB_BITS:0]   b_i,
  output logic [PROB_BITS:0]   res_o
);

  logic [2*PROB_BITS-1:0] prod;
  logic [PROB_BITS:0]     res_d;
  logic [PROB_BITS:0]     res_q;

  assign prod = a_i[PROB_BITS-1:0] * b_i[PROB_BITS-1:0];

  always_comb begin
    priority if (a_i[PROB_BITS]) begin
      res_d = b_i;
    end else if (b_i[PROB_BITS]) begin
      res_d = a_i;
    end else begin
      res_d = {1'b0, prod[2*PROB_BITS-1:PROB_BITS]};
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

>>> rtl/core/stochastic_lattice_site_update.sv
// top level: lattice memories, site update sequencer and stream ports
// load items are written as they are taken; an update reads n neighbour slots and
// multiplies once for each of its a active neighbours, using the single shared
// multiplier and the one lattice read port; it waits until the previous result is taken
// after the last site of a sweep the new states are copied into the current lattice
// after reset a clearing pass zeroes lattice and sample marks, no item taken
// configuration writes are taken in every cycle
`timescale 1ns / 1ps
`default_nettype none
module stochastic_lattice_site_update import slsu_pkg::*; #(
  parameter int unsigned SITES          = SITES_DEF,
  parameter int unsigned MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
  parameter int unsigned PROB_BITS      = PROB_BITS_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [REG_W-1:0]       cfg_wdata_i,
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  // site, slot, neighbour_site, site_active, sampled, random_fraction, zero pad
  input  wire  [IN_DATA_W-1:0]   s_axis_tdata,
  // kind
  input  wire  [KIND_FW-1:0]     s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  // updated_site, new_active, activity, sampled_activity, zero pad
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  // sweep_done
  output logic                   m_axis_tlast
);

  localparam int unsigned SITE_W = $clog2(SITES);
  localparam int unsigned NB_W   = $clog2(MAX_NEIGHBOURS + 1);
  localparam int unsigned TBL_N  = SITES * MAX_NEIGHBOURS;
  localparam int unsigned TA_W   = $clog2(TBL_N);
  localparam logic [PROB_BITS:0] ONE = {1'b1, {PROB_BITS{1'b0}}};

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_SELF, S_SELF, S_MUL_F, S_MUL_FW,
    S_TBL, S_TBLW, S_NB, S_MULW, S_DECIDE, S_COPY, S_COPY_END
  } state_e;

  state_e state_q;

  // configuration
  logic [REG_W-1:0] self_p_q, neigh_p_q, field_p_q;
  logic [NIU_W-1:0] niu_q;
  logic [SIU_W-1:0] siu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_p_q  <= '0;
      neigh_p_q <= '0;
      field_p_q <= '0;
      niu_q     <= NIU_W'(8);
      siu_q     <= SIU_W'(4096);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SELF_PROB:  self_p_q  <= cfg_wdata_i;
        REG_NEIGH_PROB: neigh_p_q <= cfg_wdata_i;
        REG_FIELD_PROB: field_p_q <= cfg_wdata_i;
        REG_NEIGH_USE:  niu_q     <= cfg_wdata_i[NIU_W-1:0];
        REG_SITES_USE:  siu_q     <= cfg_wdata_i[SIU_W-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [KIND_FW-1:0] in_kind;
  logic [SITE_FW-1:0] in_site, in_nsite;
  logic [SLOT_FW-1:0] in_slot;
  logic               in_act, in_smp;
  logic [31:0]        in_rnd;
  logic               in_acc;

  assign in_kind  = s_axis_tuser;
  assign in_site  = s_axis_tdata[11:0];
  assign in_slot  = s_axis_tdata[16:12];
  assign in_nsite = s_axis_tdata[28:17];
  assign in_act   = s_axis_tdata[29];
  assign in_smp   = s_axis_tdata[30];
  assign in_rnd   = s_axis_tdata[62:31];
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  logic site_ok, slot_ok;
  assign site_ok = 32'(in_site) < SITES;
  assign slot_ok = 32'(in_slot) < MAX_NEIGHBOURS;

  // complements
  logic [PROB_BITS:0] c_self, c_field, c_neigh;
  assign c_self  = ONE - {1'b0, self_p_q[PROB_BITS-1:0]};
  assign c_field = ONE - {1'b0, field_p_q[PROB_BITS-1:0]};
  assign c_neigh = ONE - {1'b0, neigh_p_q[PROB_BITS-1:0]};

  logic [NB_W-1:0] nn_eff;
  assign nn_eff = (32'(niu_q) > MAX_NEIGHBOURS) ? NB_W'(MAX_NEIGHBOURS) : NB_W'(niu_q);

  logic [31:0] lim32;
  always_comb begin
    priority if (siu_q == '0) begin
      lim32 = 32'd1;
    end else if (32'(siu_q) > SITES) begin
      lim32 = 32'(SITES);
    end else begin
      lim32 = 32'(siu_q);
    end
  end

  // sequencer registers
  logic [SITE_W-1:0]    pos_q, clr_q, cp_q, cp_wa_q;
  logic                 cp_wv_q;
  logic [TA_W-1:0]      base_q;
  logic [NB_W-1:0]      j_q;
  logic [PROB_BITS-1:0] rnd_q;
  logic [PROB_BITS:0]   prod_q;
  logic                 mark_q, nvalid_q;
  logic [COUNT_W-1:0]   act_cnt_q, smp_cnt_q;
  logic                 out_valid_q, out_act_q, out_last_q;
  logic [SITE_FW-1:0]   out_site_q;
  logic [COUNT_W-1:0]   out_act_cnt_q, out_smp_cnt_q;

  // memories
  logic                 cur_mem [SITES];
  logic                 smp_mem [SITES];
  logic                 nxt_mem [SITES];
  logic [SITE_FW-1:0]   tbl_mem [TBL_N];
  logic                 cur_rd_q, smp_rd_q, nxt_rd_q;
  logic [SITE_FW-1:0]   tbl_rd_q;

  logic [SITE_W-1:0] cur_ra, cur_wa;
  logic              cur_we, cur_wd;
  logic              smp_we, smp_wd;
  logic [SITE_W-1:0] smp_wa;
  logic              nxt_we;
  logic              tbl_we;
  logic [TA_W-1:0]   tbl_wa, tbl_ra;

  // multiplier
  logic [PROB_BITS:0] mul_b, mul_res;
  assign mul_b = (state_q == S_MUL_F) ? c_field : c_neigh;

  slsu_qmul #(.PROB_BITS(PROB_BITS)) u_qmul (
    .clk_i (clk_i),
    .a_i   (prod_q),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  // decision
  logic               out_free, act, last;
  logic [PROB_BITS:0] thresh;
  logic [31:0]        pos_next32;
  assign out_free   = !out_valid_q || m_axis_tready;
  assign thresh     = ONE - prod_q;
  assign act        = {1'b0, rnd_q} < thresh;
  assign pos_next32 = 32'(pos_q) + 32'd1;
  assign last       = pos_next32 >= lim32;

  always_comb begin
    unique case (state_q)
      S_TBLW:  cur_ra = SITE_W'(tbl_rd_q);
      S_COPY:  cur_ra = cp_q;
      default: cur_ra = pos_q;
    endcase
  end

  assign tbl_ra = base_q + TA_W'(j_q);
  assign tbl_wa = TA_W'(in_site) * TA_W'(MAX_NEIGHBOURS) + TA_W'(in_slot);
  assign tbl_we = in_acc && (in_kind == KIND_LOAD_NEIGH) && site_ok && slot_ok;
  assign nxt_we = (state_q == S_DECIDE) && out_free;

  always_comb begin
    cur_we = 1'b0;
    cur_wa = cp_wa_q;
    cur_wd = nxt_rd_q;
    smp_we = 1'b0;
    smp_wa = clr_q;
    smp_wd = 1'b0;
    priority if (state_q == S_CLEAR) begin
      cur_we = 1'b1;
      cur_wa = clr_q;
      cur_wd = 1'b0;
      smp_we = 1'b1;
    end else if (cp_wv_q) begin
      cur_we = 1'b1;
    end else if (in_acc && (in_kind == KIND_LOAD_SITE) && site_ok) begin
      cur_we = 1'b1;
      cur_wa = SITE_W'(in_site);
      cur_wd = in_act;
      smp_we = 1'b1;
      smp_wa = SITE_W'(in_site);
      smp_wd = in_smp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[cur_wa] <= cur_wd;
    end
    cur_rd_q <= cur_mem[cur_ra];
  end

  always_ff @(posedge clk_i) begin
    if (smp_we) begin
      smp_mem[smp_wa] <= smp_wd;
    end
    smp_rd_q <= smp_mem[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      nxt_mem[pos_q] <= act;
    end
    nxt_rd_q <= nxt_mem[cp_q];
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= in_nsite;
    end
    tbl_rd_q <= tbl_mem[tbl_ra];
  end

  assign s_axis_tready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_q         <= '0;
      pos_q         <= '0;
      base_q        <= '0;
      j_q           <= '0;
      cp_q          <= '0;
      cp_wa_q       <= '0;
      cp_wv_q       <= 1'b0;
      act_cnt_q     <= '0;
      smp_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
      out_site_q    <= '0;
      out_act_q     <= 1'b0;
      out_last_q    <= 1'b0;
      out_act_cnt_q <= '0;
      out_smp_cnt_q <= '0;
      rnd_q         <= '0;
      prod_q        <= ONE;
      mark_q        <= 1'b0;
      nvalid_q      <= 1'b0;
    end else begin
      cp_wv_q <= (state_q == S_COPY);
      if ((state_q == S_DECIDE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == SITES - 1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && (in_kind == KIND_UPDATE)) begin
            rnd_q   <= in_rnd[PROB_BITS-1:0];
            state_q <= S_RD_SELF;
          end
        end
        S_RD_SELF: state_q <= S_SELF;
        S_SELF: begin
          prod_q  <= cur_rd_q ? c_self : ONE;
          mark_q  <= smp_rd_q;
          state_q <= S_MUL_F;
        end
        S_MUL_F: state_q <= S_MUL_FW;
        S_MUL_FW: begin
          prod_q  <= mul_res;
          j_q     <= '0;
          state_q <= (nn_eff == '0) ? S_DECIDE : S_TBL;
        end
        S_TBL: state_q <= S_TBLW;
        S_TBLW: begin
          nvalid_q <= 32'(tbl_rd_q) < SITES;
          state_q  <= S_NB;
        end
        S_NB: begin
          if (nvalid_q && cur_rd_q) begin
            state_q <= S_MULW;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= (j_q + 1'b1 == nn_eff) ? S_DECIDE : S_TBL;
          end
        end
        S_MULW: begin
          prod_q  <= mul_res;
          j_q     <= j_q + 1'b1;
          state_q <= (j_q + 1'b1 == nn_eff) ? S_DECIDE : S_TBL;
        end
        S_DECIDE: begin
          if (out_free) begin
            out_site_q    <= SITE_FW'(pos_q);
            out_act_q     <= act;
            out_last_q    <= last;
            out_act_cnt_q <= (act && act_cnt_q != COUNT_MAX) ? act_cnt_q + 1'b1 : act_cnt_q;
            out_smp_cnt_q <= (act && mark_q && smp_cnt_q != COUNT_MAX) ?
                             smp_cnt_q + 1'b1 : smp_cnt_q;
            if (last) begin
              act_cnt_q <= '0;
              smp_cnt_q <= '0;
              cp_q      <= '0;
              state_q   <= S_COPY;
            end else begin
              if (act && act_cnt_q != COUNT_MAX) begin
                act_cnt_q <= act_cnt_q + 1'b1;
              end
              if (act && mark_q && smp_cnt_q != COUNT_MAX) begin
                smp_cnt_q <= smp_cnt_q + 1'b1;
              end
              pos_q   <= pos_q + 1'b1;
              base_q  <= base_q + TA_W'(MAX_NEIGHBOURS);
              state_q <= S_IDLE;
            end
          end
        end
        S_COPY: begin
          cp_wa_q <= cp_q;
          if (cp_q == pos_q) begin
            state_q <= S_COPY_END;
          end else begin
            cp_q <= cp_q + 1'b1;
          end
        end
        S_COPY_END: begin
          pos_q   <= '0;
          base_q  <= '0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {1'b0, out_smp_cnt_q, out_act_cnt_q, out_act_q, out_site_q};

endmodule
`default_nettype wire
